/* rtl/core/tsca_pkg.sv */
// Package for the temperature scratchpad checker and averager.
// Types, codes and sizes shared by the front, the queue, the back and the top level.
// No dependencies.
package tsca_pkg;

    // Scratchpad frame: bytes 0/1 carry the reading, the last byte is the CRC.
    localparam int FRAME_BYTES = 9;
    localparam int POS_W       = $clog2(FRAME_BYTES);

    localparam int BYTE_W      = 8;
    localparam int READING_W   = 16;
    localparam int SUM_W       = 24;
    localparam int STATUS_W    = 2;
    localparam int SPA_W       = 8;

    localparam logic [SPA_W-1:0] SPA_RESET = SPA_W'(4);

    // Dallas CRC-8, reflected polynomial x^8+x^5+x^4+1.
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;

    // Frame event queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Divider runs one quotient bit per cycle over the whole sum.
    localparam int DIV_STEPS = SUM_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCUM   = 2'd0,
        ST_CRC_ERR = 2'd1,
        ST_AVERAGE = 2'd2
    } t_status;

    // One finished frame, as classified by the front.
    typedef struct packed {
        logic                 crc_ok;
        logic [READING_W-1:0] reading;
    } t_frame_evt;

endpackage

/* rtl/core/tsca_if.sv */
// Valid/ready channel interfaces for scratchpad bytes and frame results.
// Depends on tsca_pkg for field widths.
interface tsca_byte_if;
    logic                        valid;
    logic                        ready;
    logic [tsca_pkg::BYTE_W-1:0] scratch_byte;

    modport source (output valid, output scratch_byte, input ready);
    modport sink   (input valid, input scratch_byte, output ready);
endinterface

interface tsca_result_if;
    logic                                  valid;
    logic                                  ready;
    logic [tsca_pkg::STATUS_W-1:0]         frame_status;
    logic signed [tsca_pkg::READING_W-1:0] average_temperature;

    modport source (output valid, output frame_status, output average_temperature,
                    input ready);
    modport sink   (input valid, input frame_status, input average_temperature,
                    output ready);
endinterface

/* rtl/core/tsca_front.sv */
// Front end: takes scratchpad bytes, tracks frame position, CRC and reading bytes.
// Emits one frame event per frame into the queue. Depends on tsca_pkg.
module tsca_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [tsca_pkg::BYTE_W-1:0]   i_byte,
    output logic                          o_ready,
    input  logic                          i_full,
    output logic                          o_push,
    output tsca_pkg::t_frame_evt          o_evt
);

    localparam logic [tsca_pkg::POS_W-1:0] LAST_POS = tsca_pkg::POS_W'(tsca_pkg::FRAME_BYTES - 1);

    function automatic logic [tsca_pkg::BYTE_W-1:0] crc_update(
        input logic [tsca_pkg::BYTE_W-1:0] crc_in,
        input logic [tsca_pkg::BYTE_W-1:0] data_in
    );
        logic [tsca_pkg::BYTE_W-1:0] crc;
        logic [tsca_pkg::BYTE_W-1:0] d;
        logic                        mix;
        crc = crc_in;
        d   = data_in;
        for (int k = 0; k < tsca_pkg::BYTE_W; k++) begin
            mix = crc[0] ^ d[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ tsca_pkg::CRC_POLY;
            end
            d = d >> 1;
        end
        return crc;
    endfunction

    logic [tsca_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [tsca_pkg::BYTE_W-1:0] r_crc, n_crc;
    logic [tsca_pkg::BYTE_W-1:0] r_lo, n_lo;
    logic [tsca_pkg::BYTE_W-1:0] r_hi, n_hi;
    logic                        take;
    logic                        last;

    assign o_ready = !i_full;
    assign take    = i_valid && o_ready;
    assign last    = (r_pos == LAST_POS);

    assign o_push         = take && last;
    assign o_evt.crc_ok   = (r_crc == i_byte);
    assign o_evt.reading  = {r_hi, r_lo};

    always_comb begin
        n_pos = r_pos;
        n_crc = r_crc;
        n_lo  = r_lo;
        n_hi  = r_hi;
        if (take) begin
            if (last) begin
                n_pos = '0;
                n_crc = '0;
            end else begin
                if (r_pos == '0) begin
                    n_lo = i_byte;
                end
                if (r_pos == tsca_pkg::POS_W'(1)) begin
                    n_hi = i_byte;
                end
                n_crc = crc_update(r_crc, i_byte);
                n_pos = r_pos + tsca_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= '0;
            r_lo  <= '0;
            r_hi  <= '0;
        end else begin
            r_pos <= n_pos;
            r_crc <= n_crc;
            r_lo  <= n_lo;
            r_hi  <= n_hi;
        end
    end

endmodule

/* rtl/core/tsca_queue.sv */
// Short frame event queue between front and back.
// Depends on tsca_pkg for depth and entry type.
module tsca_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  tsca_pkg::t_frame_evt i_evt,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output tsca_pkg::t_frame_evt o_evt
);

    tsca_pkg::t_frame_evt r_mem [tsca_pkg::QUEUE_DEPTH];

    logic [tsca_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [tsca_pkg::QUEUE_AW:0]   r_cnt;
    logic                          do_push, do_pop;

    assign o_full  = (r_cnt == (tsca_pkg::QUEUE_AW+1)'(tsca_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_evt   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    function automatic logic [tsca_pkg::QUEUE_AW-1:0] ptr_next(
        input logic [tsca_pkg::QUEUE_AW-1:0] p
    );
        if (p == tsca_pkg::QUEUE_AW'(tsca_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + tsca_pkg::QUEUE_AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (tsca_pkg::QUEUE_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (tsca_pkg::QUEUE_AW+1)'(1);
            end
        end
    end

endmodule

/* rtl/core/tsca_back.sv */
// Back end: sample count, signed sum, serial divider and the result register.
// Holds the samples-per-average register. Depends on tsca_pkg.
module tsca_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [tsca_pkg::SPA_W-1:0]            i_cfg_data,
    input  logic                                  i_empty,
    input  tsca_pkg::t_frame_evt                  i_evt,
    output logic                                  o_pop,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [tsca_pkg::STATUS_W-1:0]         o_status,
    output logic signed [tsca_pkg::READING_W-1:0] o_avg
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                             r_state, n_state;
    logic [tsca_pkg::SPA_W-1:0]         r_spa;
    logic [tsca_pkg::SPA_W-1:0]         r_cnt, n_cnt;
    logic [tsca_pkg::SUM_W-1:0]         r_sum, n_sum;
    logic [tsca_pkg::SPA_W-1:0]         r_div, n_div;
    logic [tsca_pkg::SUM_W-1:0]         r_quo, n_quo;
    logic [tsca_pkg::SPA_W-1:0]         r_rem, n_rem;
    logic                               r_neg, n_neg;
    logic [tsca_pkg::STEP_W-1:0]        r_step, n_step;
    logic                               r_out_valid, n_out_valid;
    logic [tsca_pkg::STATUS_W-1:0]      r_out_status, n_out_status;
    logic [tsca_pkg::READING_W-1:0]     r_out_avg, n_out_avg;

    logic                               slot_free;
    logic [tsca_pkg::SUM_W-1:0]         reading_ext;
    logic [tsca_pkg::SPA_W:0]           rem_sh;
    logic [tsca_pkg::SPA_W:0]           rem_sub;
    logic                               ge;

    assign slot_free   = !r_out_valid || i_ready;
    assign reading_ext = {{(tsca_pkg::SUM_W - tsca_pkg::READING_W){i_evt.reading[tsca_pkg::READING_W-1]}},
                          i_evt.reading};
    assign o_pop       = (r_state == S_IDLE) && !i_empty && slot_free;

    // restoring divide step
    assign rem_sh  = {r_rem, r_quo[tsca_pkg::SUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_div});
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_sum        = r_sum;
        n_div        = r_div;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_neg        = r_neg;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_avg    = r_out_avg;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    if (!i_evt.crc_ok) begin
                        n_cnt        = '0;
                        n_sum        = '0;
                        n_out_valid  = 1'b1;
                        n_out_status = tsca_pkg::ST_CRC_ERR;
                        n_out_avg    = '0;
                    end else if (r_cnt < r_spa) begin
                        n_cnt        = r_cnt + tsca_pkg::SPA_W'(1);
                        n_sum        = r_sum + reading_ext;
                        n_out_valid  = 1'b1;
                        n_out_status = tsca_pkg::ST_ACCUM;
                        n_out_avg    = '0;
                    end else if (r_spa == '0) begin
                        n_cnt        = '0;
                        n_sum        = '0;
                        n_out_valid  = 1'b1;
                        n_out_status = tsca_pkg::ST_AVERAGE;
                        n_out_avg    = '0;
                    end else begin
                        n_cnt   = '0;
                        n_sum   = '0;
                        n_div   = r_spa;
                        n_neg   = r_sum[tsca_pkg::SUM_W-1];
                        n_quo   = r_sum[tsca_pkg::SUM_W-1] ? (~r_sum + tsca_pkg::SUM_W'(1)) : r_sum;
                        n_rem   = '0;
                        n_step  = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_quo  = {r_quo[tsca_pkg::SUM_W-2:0], ge};
                n_rem  = ge ? rem_sub[tsca_pkg::SPA_W-1:0] : rem_sh[tsca_pkg::SPA_W-1:0];
                n_step = r_step + tsca_pkg::STEP_W'(1);
                if (r_step == tsca_pkg::STEP_W'(tsca_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = tsca_pkg::ST_AVERAGE;
                    n_out_avg    = r_neg ? (~r_quo[tsca_pkg::READING_W-1:0] + tsca_pkg::READING_W'(1))
                                         : r_quo[tsca_pkg::READING_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_spa       <= tsca_pkg::SPA_RESET;
            r_cnt       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sum       <= n_sum;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_spa <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_div        <= n_div;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_neg        <= n_neg;
        r_step       <= n_step;
        r_out_status <= n_out_status;
        r_out_avg    <= n_out_avg;
    end

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;
    assign o_avg    = r_out_avg;

endmodule

/* rtl/core/temp_scratchpad_check_average_top.sv */
// Top level of the temperature scratchpad checker and averager.
// Depends on tsca_pkg, tsca_if, tsca_front, tsca_queue and tsca_back.
//
//  channel   | dir | handshake          | payload
//  ----------+-----+--------------------+--------------------------------------
//  i_byte    | in  | valid/ready        | scratch_byte[7:0]
//  o_result  | out | valid/ready        | frame_status[1:0], average_temperature
//  i_cfg_*   | in  | write enable only  | samples_per_average[7:0]
//
// Bytes are taken one per cycle while the frame queue has room; non-final
// bytes produce no item. A frame's last byte yields one result item:
// accumulate, CRC error and zero-divisor frames go straight to the result
// register; an average first runs the one-bit-per-cycle serial divider.
// Reset (i_rst_n low at a clock edge) clears position, CRC, count, sum and
// restores samples_per_average to 4. A stalled output holds its item; the
// front keeps taking bytes until the two-entry queue fills.
module temp_scratchpad_check_average_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tsca_byte_if.sink                  i_byte,
    tsca_result_if.source              o_result,
    input  logic                       i_cfg_we,
    input  logic [tsca_pkg::SPA_W-1:0] i_cfg_data
);

    logic                 q_full;
    logic                 q_empty;
    logic                 q_push;
    logic                 q_pop;
    tsca_pkg::t_frame_evt push_evt;
    tsca_pkg::t_frame_evt pop_evt;

    // front: frame position, CRC, reading capture
    tsca_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_byte.valid),
        .i_byte  (i_byte.scratch_byte),
        .o_ready (i_byte.ready),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_evt   (push_evt)
    );

    // decouples byte intake from the divider
    tsca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_evt   (push_evt),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_evt   (pop_evt)
    );

    // back: accumulation, average, result register
    tsca_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_empty    (q_empty),
        .i_evt      (pop_evt),
        .o_pop      (q_pop),
        .o_valid    (o_result.valid),
        .i_ready    (o_result.ready),
        .o_status   (o_result.frame_status),
        .o_avg      (o_result.average_temperature)
    );

endmodule

/* rtl/core/tsca_checker.sv */
// Port-level checks for the temperature scratchpad checker and averager.
// Bound to temp_scratchpad_check_average_top; depends on tsca_pkg.
module tsca_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic [tsca_pkg::STATUS_W-1:0]         i_status,
    input logic signed [tsca_pkg::READING_W-1:0] i_avg
);

    // result register empties on reset
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status) && $stable(i_avg))
        else $error("result changed while stalled");

    // average field is zero unless an average is reported
    a_avg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != tsca_pkg::ST_AVERAGE) |-> i_avg == '0)
        else $error("nonzero average on non-average item");

endmodule

bind temp_scratchpad_check_average_top tsca_checker u_tsca_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_status    (o_result.frame_status),
    .i_avg       (o_result.average_temperature)
);

/* verif/tb_temp_scratchpad_check_average_top.sv */
`timescale 1ns / 1ps
// Self-checking bench for temp_scratchpad_check_average_top: feeds scratchpad frames,
// predicts each frame's status and average, and checks every result item.
// Depends on tsca_pkg, tsca_if and the block's RTL.
module tb_temp_scratchpad_check_average_top;
    import tsca_pkg::*;

    localparam int     CLK_PERIOD   = 8;
    localparam int     RESET_CYCLES = 5;
    // Leave room for the divider and a queued frame behind it.
    localparam int     SETTLE       = 64;
    localparam longint CYCLE_LIMIT  = 600000;
    localparam int     SHOWN_ERRORS = 10;
    localparam int     PLAN_PHASES  = 12;

    localparam logic [READING_W-1:0] COLDEST  = 16'h8000;
    localparam logic [READING_W-1:0] HOTTEST  = 16'h7fff;
    localparam logic [READING_W-1:0] MINUS_1  = 16'hffff;
    localparam logic [READING_W-1:0] ZERO_RDG = 16'h0000;

    // One expected frame result.
    typedef struct {
        t_status                      status;
        logic signed [READING_W-1:0]  average;
    } t_frame_report;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [SPA_W-1:0]    i_cfg_data;

    tsca_byte_if   byte_ch ();
    tsca_result_if result_ch ();

    temp_scratchpad_check_average_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_byte     (byte_ch),
        .o_result   (result_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // ---------------------------------------------------------------------
    // Predictor state: mirrors the block's frame tracking and accumulation.
    // ---------------------------------------------------------------------
    int unsigned         frame_pos;
    logic [BYTE_W-1:0]   frame_crc;
    logic [BYTE_W-1:0]   temp_lo;
    logic [BYTE_W-1:0]   temp_hi;
    logic [SPA_W-1:0]    held_count;
    logic [SPA_W-1:0]    spa_now;
    int                  temp_sum;

    t_frame_report       pending_reports[$];   // expected results, oldest first
    logic [BYTE_W-1:0]   bytes_to_send[$];     // stimulus not yet presented
    int unsigned         gen_pos;              // generator's own frame position

    bit                  steady_flow;          // phase runs with no idling at all
    int unsigned         mismatches = 0;
    longint              cycles = 0;
    int                  send_gap;
    int                  stall_left;

    // ---------------------------------------------------------------------
    // Dallas CRC-8, reflected form, one byte LSB first.
    // ---------------------------------------------------------------------
    function automatic logic [BYTE_W-1:0] dallas_crc8_step(logic [BYTE_W-1:0] crc,
                                                           logic [BYTE_W-1:0] b);
        logic mix;
        for (int k = 0; k < BYTE_W; k++) begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

    // Advance the predictor by one accepted byte; a frame's last byte
    // queues exactly one expected result.
    function automatic void absorb_scratch_byte(logic [BYTE_W-1:0] b);
        t_frame_report               rep;
        logic signed [READING_W-1:0] reading;
        if (frame_pos < FRAME_BYTES - 1) begin
            if (frame_pos == 0) begin
                temp_lo = b;
            end else if (frame_pos == 1) begin
                temp_hi = b;
            end
            frame_crc = dallas_crc8_step(frame_crc, b);
            frame_pos++;
            return;
        end
        rep.average = '0;
        if (frame_crc != b) begin
            // bad CRC throws away everything summed so far
            held_count = '0;
            temp_sum   = 0;
            rep.status = ST_CRC_ERR;
        end else begin
            reading = {temp_hi, temp_lo};
            if (held_count < spa_now) begin
                held_count++;
                temp_sum  += reading;
                rep.status = ST_ACCUM;
            end else begin
                // this frame's reading is dropped; zero divisor gives 0
                if (spa_now != '0) begin
                    rep.average = READING_W'(temp_sum / int'(spa_now));
                end
                held_count = '0;
                temp_sum   = 0;
                rep.status = ST_AVERAGE;
            end
        end
        frame_pos = 0;
        frame_crc = '0;
        pending_reports.push_back(rep);
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus generation (no time passes here).
    // ---------------------------------------------------------------------
    function automatic void queue_byte(logic [BYTE_W-1:0] b);
        bytes_to_send.push_back(b);
        gen_pos = (gen_pos + 1) % FRAME_BYTES;
    endfunction

    // Full frame: reading in bytes 0/1, random filler, then CRC (corrupted if bad).
    function automatic void queue_frame(logic [READING_W-1:0] reading, bit good);
        logic [BYTE_W-1:0] fb;
        logic [BYTE_W-1:0] crc;
        crc = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++) begin
            if (i == 0) begin
                fb = reading[7:0];
            end else if (i == 1) begin
                fb = reading[15:8];
            end else begin
                fb = BYTE_W'($urandom);
            end
            crc = dallas_crc8_step(crc, fb);
            queue_byte(fb);
        end
        if (!good) begin
            crc = crc ^ BYTE_W'($urandom_range(1, 255));
        end
        queue_byte(crc);
    endfunction

    function automatic logic [READING_W-1:0] pick_reading();
        int unsigned pick;
        pick = $urandom_range(0, 15);
        case (pick)
            0: return COLDEST;
            1: return HOTTEST;
            2: return MINUS_1;
            3: return ZERO_RDG;
            4, 5, 6, 7: return READING_W'(int'($urandom_range(0, 2800)) - 880);
            default: return READING_W'($urandom);
        endcase
    endfunction

    // Mostly well-formed frames; some bad CRCs, pure noise frames and
    // short junk bursts that the next call pads out to a frame boundary.
    function automatic void queue_random_frame();
        int unsigned kind;
        while (gen_pos != 0) begin
            queue_byte(BYTE_W'($urandom));
        end
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            repeat ($urandom_range(1, FRAME_BYTES - 1)) queue_byte(BYTE_W'($urandom));
        end else if (kind < 10) begin
            repeat (FRAME_BYTES) queue_byte(BYTE_W'($urandom));
        end else begin
            queue_frame(pick_reading(), kind >= 22);
        end
    endfunction

    // Mostly short gaps, now and then a long one; none in steady phases.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 55) begin
            return 0;
        end
        if (r < 85) begin
            return $urandom_range(1, 3);
        end
        if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // ---------------------------------------------------------------------
    // Clock.
    // ---------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Byte driver: presents queued bytes, idles by pick_gap after each one.
    // The predictor sees each byte at the edge where it is accepted.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            byte_ch.valid        <= 1'b0;
            byte_ch.scratch_byte <= '0;
            send_gap             <= 0;
            frame_pos             = 0;
            frame_crc             = '0;
            temp_lo               = '0;
            temp_hi               = '0;
            held_count            = '0;
            temp_sum              = 0;
        end else begin
            if (byte_ch.valid && byte_ch.ready) begin
                absorb_scratch_byte(byte_ch.scratch_byte);
            end
            // slot is free when nothing is held or the held item just went
            if (!byte_ch.valid || byte_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap      <= send_gap - 1;
                    byte_ch.valid <= 1'b0;
                end else if (bytes_to_send.size() != 0) begin
                    byte_ch.valid        <= 1'b1;
                    byte_ch.scratch_byte <= bytes_to_send.pop_front();
                    send_gap             <= pick_gap();
                end else begin
                    byte_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Result monitor: random back-pressure, in-order field checks.
    // ---------------------------------------------------------------------
    function automatic void flag_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= SHOWN_ERRORS) begin
            $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_report want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                if (pending_reports.size() == 0) begin
                    flag_mismatch("unexpected result item (status)", -1,
                                  int'(result_ch.frame_status));
                end else begin
                    want = pending_reports.pop_front();
                    if (result_ch.frame_status != want.status) begin
                        flag_mismatch("frame_status", int'(want.status),
                                      int'(result_ch.frame_status));
                    end
                    if (result_ch.average_temperature != want.average) begin
                        flag_mismatch("average_temperature", int'(want.average),
                                      int'(result_ch.average_temperature));
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left      <= stall_left - 1;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
                if (!steady_flow && $urandom_range(0, 3) == 0) begin
                    stall_left <= pick_gap();
                end
            end
        end
    end

    // Hard stop if the block hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** temp_scratchpad_check_average_top: FAILED **");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencing helpers.
    // ---------------------------------------------------------------------
    // Block is idle once every byte went in and every result came out;
    // checked at the falling edge so all edge updates have landed.
    task automatic wait_idle();
        while (bytes_to_send.size() != 0 || byte_ch.valid || pending_reports.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_spa(logic [SPA_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        spa_now     = value;
    endtask

    // ---------------------------------------------------------------------
    // Main sequence.
    // ---------------------------------------------------------------------
    initial begin
        // Sample-count plan: wide and narrow settings mixed, random ones
        // in between; zero divisor appears too.
        logic [SPA_W-1:0] spa_plan [PLAN_PHASES];
        spa_plan = '{8'd255, 8'd17, 8'd0, 8'd4, 8'd1, 8'd2,
                     8'd9, 8'd0, 8'd3, 8'd128, 8'd0, 8'd6};
        spa_plan[7]  = SPA_W'($urandom_range(1, 255));
        spa_plan[10] = SPA_W'($urandom_range(1, 255));

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= '0;

        spa_now     = SPA_RESET;
        gen_pos     = 0;
        steady_flow = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: with one sample per average, the most negative reading
        // is summed, the next good frame reports it (its own reading is
        // dropped), then a corrupted CRC.
        write_spa(SPA_W'(1));
        queue_frame(COLDEST, 1'b1);
        queue_frame(HOTTEST, 1'b1);
        queue_frame(MINUS_1, 1'b0);
        wait_idle();

        // Directed: the setting drops below the count already held, so the
        // next good frame reports the average at once.
        write_spa(SPA_W'(255));
        repeat (5) queue_frame(pick_reading(), 1'b1);
        wait_idle();
        write_spa(SPA_W'(2));
        queue_frame(pick_reading(), 1'b1);
        wait_idle();

        // Random phases; each ends with the sender holding off until all
        // results are in, so the register is only written while idle.
        for (int p = 0; p < PLAN_PHASES; p++) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            write_spa(spa_plan[p]);
            repeat ($urandom_range(16, 19)) queue_random_frame();
            while (gen_pos != 0) begin
                queue_byte(BYTE_W'($urandom));
            end
            wait_idle();
        end

        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("** temp_scratchpad_check_average_top: PASSED **");
        end else begin
            $display("** temp_scratchpad_check_average_top: FAILED **");
        end
        $finish;
    end

endmodule
